// ===== hdl/ttp_pkg.sv =====
// Shared constants, tag table and helper functions for the telemetry text parser.
package ttp_pkg;

  // Default configuration
  localparam int FRACTION_DIGITS_DEF = 4;
  localparam int FRACTION_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // Stream widths
  localparam int IN_W   = 8;
  localparam int USER_W = 1;
  localparam int OUT_W  = 40;
  localparam int CHAN_W = 4;
  localparam int VAL_W  = 32;
  localparam int FCNT_W = 3;

  // Character codes
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Known tags, oldest letter in the top byte
  localparam int NUM_CHANNELS = 13;
  localparam logic [23:0] TAG_CODE [NUM_CHANNELS] = '{
    24'h616378, 24'h616379, 24'h61637A,   // acx acy acz
    24'h617678, 24'h617679, 24'h61767A,   // avx avy avz
    24'h616778, 24'h616779, 24'h61677A,   // agx agy agz
    24'h74656D, 24'h006F69,               // tem oi
    24'h6C7466, 24'h6C7473                // ltf lts
  };
  localparam logic [2:0] TAG_LEN [NUM_CHANNELS] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3
  };

  // 10^n, for elaboration-time sizing and constant tables
  function automatic int unsigned pow10(input int unsigned n);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < n; i++) begin
      r = r * 10;
    end
    return r;
  endfunction

  // Returns {hit, channel}
  function automatic logic [CHAN_W:0] tag_lookup(input logic [23:0] letters,
                                                 input logic [2:0]  len);
    logic [CHAN_W:0] r;
    r = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (len == TAG_LEN[k] && letters == TAG_CODE[k]) begin
        r = {1'b1, CHAN_W'(k)};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/ttp_front.sv =====
// Front end: tag and number accumulators, one byte per cycle while take is high, builds finish records.
module ttp_front #(
  parameter int FRACTION_DIGITS = ttp_pkg::FRACTION_DIGITS_DEF,
  parameter int FRACTION_BITS   = ttp_pkg::FRACTION_BITS_DEF,
  parameter int REC_W           = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,          // byte accepted this cycle
  input  logic [7:0]       byte_in,
  input  logic             buffer_start,
  output logic             emit,          // record to queue (qualified by take)
  output logic [REC_W-1:0] rec            // {chan, neg, ovf, ok, fcnt, frac, int}
);

  localparam int IW  = 31 - FRACTION_BITS;
  localparam int FDW = $clog2(ttp_pkg::pow10(FRACTION_DIGITS));
  localparam logic [IW+3:0]  INT_LIMIT = (IW+4)'((1 << IW) - 1);
  localparam logic [2:0]     FD_MAX    = 3'(FRACTION_DIGITS);

  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_TRAIL
  } phase_t;

  // State
  logic [23:0]   tag_letters, tag_letters_next;
  logic [2:0]    tag_length, tag_length_next;
  logic          number_present, number_present_next;
  logic          negative_sign, negative_sign_next;
  logic [IW-1:0] integer_accum, integer_accum_next;
  logic          integer_overflow, integer_overflow_next;
  logic [FDW-1:0] fraction_accum, fraction_accum_next;
  logic [2:0]    fraction_count, fraction_count_next;
  phase_t        parse_phase, parse_phase_next;
  logic          number_invalid, number_invalid_next;

  // Byte classes
  logic          is_letter, is_digit, is_space;
  logic [3:0]    digit;
  logic [IW+3:0] int_prod;
  logic [FDW+3:0] frac_prod;
  logic [ttp_pkg::CHAN_W:0] hit;
  logic          num_ok;

  assign is_letter = byte_in inside {[ttp_pkg::CH_A:ttp_pkg::CH_Z]};
  assign is_digit  = byte_in inside {[ttp_pkg::CH_0:ttp_pkg::CH_9]};
  assign is_space  = byte_in inside {ttp_pkg::CH_SPACE, [ttp_pkg::CH_TAB:ttp_pkg::CH_CR]};
  assign digit     = 4'(byte_in - ttp_pkg::CH_0);

  // Next state for one byte
  always_comb begin
    tag_letters_next      = tag_letters;
    tag_length_next       = tag_length;
    number_present_next   = number_present;
    negative_sign_next    = negative_sign;
    integer_accum_next    = integer_accum;
    integer_overflow_next = integer_overflow;
    fraction_accum_next   = fraction_accum;
    fraction_count_next   = fraction_count;
    parse_phase_next      = parse_phase;
    number_invalid_next   = number_invalid;
    emit      = 1'b0;
    rec       = '0;
    hit       = '0;
    num_ok    = 1'b0;
    int_prod  = '0;
    frac_prod = '0;

    if (buffer_start) begin
      tag_letters_next      = '0;
      tag_length_next       = '0;
      number_present_next   = 1'b0;
      negative_sign_next    = 1'b0;
      integer_accum_next    = '0;
      integer_overflow_next = 1'b0;
      fraction_accum_next   = '0;
      fraction_count_next   = '0;
      parse_phase_next      = PH_LEAD;
      number_invalid_next   = 1'b0;
    end

    if (is_letter) begin
      // Letter closes a pending number
      if (number_present_next) begin
        hit    = ttp_pkg::tag_lookup(tag_letters_next, tag_length_next);
        emit   = hit[ttp_pkg::CHAN_W];
        num_ok = !number_invalid_next &&
                 (parse_phase_next == PH_INT || parse_phase_next == PH_FRAC ||
                  parse_phase_next == PH_TRAIL);
        rec = {hit[ttp_pkg::CHAN_W-1:0], negative_sign_next, integer_overflow_next,
               num_ok, fraction_count_next, fraction_accum_next, integer_accum_next};
        tag_letters_next      = '0;
        tag_length_next       = '0;
        number_present_next   = 1'b0;
        negative_sign_next    = 1'b0;
        integer_accum_next    = '0;
        integer_overflow_next = 1'b0;
        fraction_accum_next   = '0;
        fraction_count_next   = '0;
        parse_phase_next      = PH_LEAD;
        number_invalid_next   = 1'b0;
      end
      if (byte_in != ttp_pkg::CH_D) begin
        tag_letters_next = {tag_letters_next[15:0], byte_in};
        if (tag_length_next < 3'd4) begin
          tag_length_next = tag_length_next + 3'd1;
        end
      end
    end else begin
      number_present_next = 1'b1;
      int_prod  = (IW+4)'(integer_accum_next) * (IW+4)'(10) + (IW+4)'(digit);
      frac_prod = (FDW+4)'(fraction_accum_next) * (FDW+4)'(10) + (FDW+4)'(digit);
      if (!number_invalid_next) begin
        case (parse_phase_next)
          PH_LEAD: begin
            if (is_space) begin
            end else if (byte_in == ttp_pkg::CH_PLUS || byte_in == ttp_pkg::CH_MINUS) begin
              negative_sign_next = (byte_in == ttp_pkg::CH_MINUS);
              parse_phase_next   = PH_SIGN;
            end else if (is_digit) begin
              parse_phase_next = PH_INT;
            end else if (byte_in == ttp_pkg::CH_DOT) begin
              parse_phase_next = PH_DOT;
            end else begin
              number_invalid_next = 1'b1;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              parse_phase_next = PH_INT;
            end else if (byte_in == ttp_pkg::CH_DOT) begin
              parse_phase_next = PH_DOT;
            end else begin
              number_invalid_next = 1'b1;
            end
          end
          PH_INT: begin
            if (is_digit) begin
            end else if (byte_in == ttp_pkg::CH_DOT) begin
              parse_phase_next = PH_FRAC;
            end else if (is_space) begin
              parse_phase_next = PH_TRAIL;
            end else begin
              number_invalid_next = 1'b1;
            end
          end
          PH_DOT: begin
            if (is_digit) begin
              parse_phase_next = PH_FRAC;
            end else begin
              number_invalid_next = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
            end else if (is_space) begin
              parse_phase_next = PH_TRAIL;
            end else begin
              number_invalid_next = 1'b1;
            end
          end
          PH_TRAIL: begin
            if (!is_space) begin
              number_invalid_next = 1'b1;
            end
          end
          default: begin
            number_invalid_next = 1'b1;
          end
        endcase

        // Digit into the integer part (lead, sign, int phases)
        if (is_digit && (parse_phase == PH_LEAD || parse_phase == PH_SIGN ||
                         parse_phase == PH_INT || buffer_start) &&
            (parse_phase_next == PH_INT) && !integer_overflow_next) begin
          if (int_prod > INT_LIMIT) begin
            integer_overflow_next = 1'b1;
            integer_accum_next    = IW'(INT_LIMIT);
          end else begin
            integer_accum_next = IW'(int_prod);
          end
        end

        // Digit into the fraction (dot-only or fraction phases)
        if (is_digit && parse_phase_next == PH_FRAC && fraction_count_next < FD_MAX) begin
          fraction_accum_next = FDW'(frac_prod);
          fraction_count_next = fraction_count_next + 3'd1;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_letters      <= '0;
      tag_length       <= '0;
      number_present   <= 1'b0;
      negative_sign    <= 1'b0;
      integer_accum    <= '0;
      integer_overflow <= 1'b0;
      fraction_accum   <= '0;
      fraction_count   <= '0;
      parse_phase      <= PH_LEAD;
      number_invalid   <= 1'b0;
    end else if (take) begin
      tag_letters      <= tag_letters_next;
      tag_length       <= tag_length_next;
      number_present   <= number_present_next;
      negative_sign    <= negative_sign_next;
      integer_accum    <= integer_accum_next;
      integer_overflow <= integer_overflow_next;
      fraction_accum   <= fraction_accum_next;
      fraction_count   <= fraction_count_next;
      parse_phase      <= parse_phase_next;
      number_invalid   <= number_invalid_next;
    end
  end

endmodule

// ===== hdl/ttp_queue.sv =====
// Small register queue between the front end and the converter.
module ttp_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = ttp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/ttp_back.sv =====
// Back end: pipelined fraction-to-binary divider, range clamp and output register.
module ttp_back #(
  parameter int FRACTION_DIGITS = ttp_pkg::FRACTION_DIGITS_DEF,
  parameter int FRACTION_BITS   = ttp_pkg::FRACTION_BITS_DEF,
  parameter int REC_W           = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [REC_W-1:0]          rec,
  input  logic                      empty,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [ttp_pkg::OUT_W-1:0] m_tdata
);

  localparam int IW  = 31 - FRACTION_BITS;
  localparam int FDW = $clog2(ttp_pkg::pow10(FRACTION_DIGITS));
  localparam int PW  = $clog2(ttp_pkg::pow10(FRACTION_DIGITS) + 1);
  localparam int Q   = FRACTION_BITS + 1;          // quotient bits
  localparam int NW  = FDW + FRACTION_BITS + 1;    // dividend bits
  localparam int CW  = ttp_pkg::CHAN_W;
  localparam int VW  = ttp_pkg::VAL_W;

  // Record fields
  logic [CW-1:0]  r_chan;
  logic           r_neg, r_ovf, r_ok;
  logic [2:0]     r_fcnt;
  logic [FDW-1:0] r_frac;
  logic [IW-1:0]  r_int;
  logic [PW-1:0]  p_sel;
  logic [NW-1:0]  dividend;
  logic           en;

  assign {r_chan, r_neg, r_ovf, r_ok, r_fcnt, r_frac, r_int} = rec;

  // Whole pipeline moves when the output slot can take a result
  assign en  = !m_tvalid || m_tready;
  assign pop = en && !empty;

  // Divisor 10^count; dividend frac*2^FB + divisor/2 (round half up)
  always_comb begin
    p_sel = PW'(1);
    for (int k = 0; k <= FRACTION_DIGITS; k++) begin
      if (r_fcnt == 3'(k)) begin
        p_sel = PW'(ttp_pkg::pow10(k));
      end
    end
    dividend = (NW'(r_frac) << FRACTION_BITS) + NW'(p_sel >> 1);
  end

  // Stage registers
  logic [Q:0]     st_vld;
  logic [PW-1:0]  st_rem  [Q+1];
  logic [Q-1:0]   st_nlo  [Q+1];
  logic [Q-1:0]   st_q    [Q+1];
  logic [PW-1:0]  st_p    [Q+1];
  logic [CW-1:0]  st_chan [Q+1];
  logic           st_neg  [Q+1];
  logic           st_ovf  [Q+1];
  logic           st_ok   [Q+1];
  logic [IW-1:0]  st_int  [Q+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (en) begin
      st_vld <= {st_vld[Q-1:0], pop};
    end
  end

  // Load: high dividend bits are already below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      st_rem[0]  <= PW'(dividend[NW-1:Q]);
      st_nlo[0]  <= dividend[Q-1:0];
      st_q[0]    <= '0;
      st_p[0]    <= p_sel;
      st_chan[0] <= r_chan;
      st_neg[0]  <= r_neg;
      st_ovf[0]  <= r_ovf;
      st_ok[0]   <= r_ok;
      st_int[0]  <= r_int;
    end
  end

  // One restoring-division bit per stage
  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [PW:0] trial;
    logic        ge;
    assign trial = {st_rem[k], st_nlo[k][Q-1]};
    assign ge    = trial >= {1'b0, st_p[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1]  <= ge ? PW'(trial - {1'b0, st_p[k]}) : trial[PW-1:0];
        st_nlo[k+1]  <= {st_nlo[k][Q-2:0], 1'b0};
        st_q[k+1]    <= {st_q[k][Q-2:0], ge};
        st_p[k+1]    <= st_p[k];
        st_chan[k+1] <= st_chan[k];
        st_neg[k+1]  <= st_neg[k];
        st_ovf[k+1]  <= st_ovf[k];
        st_ok[k+1]   <= st_ok[k];
        st_int[k+1]  <= st_int[k];
      end
    end
  end

  // Assemble magnitude, clamp, apply sign
  logic [VW-1:0] mag, limit, value;
  logic          sat;

  always_comb begin
    mag   = (VW'(st_int[Q]) << FRACTION_BITS) + VW'(st_q[Q]);
    limit = st_neg[Q] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat   = 1'b0;
    value = '0;
    if (st_ok[Q]) begin
      if (st_ovf[Q] || mag > limit) begin
        sat = 1'b1;
        mag = limit;
      end
      value = st_neg[Q] ? (VW'(0) - mag) : mag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= st_vld[Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en && st_vld[Q]) begin
      m_tdata <= {(ttp_pkg::OUT_W - CW - VW - 1)'(0), sat, value, st_chan[Q]};
    end
  end

  // Checks
  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[CW-1:0] < CW'(ttp_pkg::NUM_CHANNELS))
    else $error("channel out of range");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[CW+VW] |->
      m_tdata[CW+VW-1:CW] == 32'h7FFF_FFFF || m_tdata[CW+VW-1:CW] == 32'h8000_0000)
    else $error("saturated value is not a range limit");

  a_pop_loads: assert property (@(posedge clk) disable iff (rst)
    pop |=> st_vld[0])
    else $error("popped record not loaded into divider");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    en && st_vld[Q] |=> m_tvalid)
    else $error("finished result lost at output register");

endmodule

// ===== hdl/tagged_telemetry_text_parser.sv =====
// Top level of the tagged telemetry text parser.
//
//  port group   dir  tdata / tuser contents (lsb first)            item
//  s_*          in   tdata: byte_in[7:0]; tuser: buffer_start       one text byte
//  m_*          out  tdata: channel[3:0], value[35:4], saturated[36] one tagged value
//
// One byte is taken every cycle while the record queue has room.
// A result passes from the letter that closes its number through the queue, the
// load register, FRACTION_BITS+1 divider stages and the output register.
// Reset clears the accumulators, the queue and the divider pipeline.
// A stalled output freezes the divider; input stalls only once the queue is full.
module tagged_telemetry_text_parser #(
  parameter int FRACTION_DIGITS = ttp_pkg::FRACTION_DIGITS_DEF,
  parameter int FRACTION_BITS   = ttp_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH     = ttp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [ttp_pkg::IN_W-1:0]   s_tdata,   // byte_in
  input  logic [ttp_pkg::USER_W-1:0] s_tuser,   // buffer_start
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ttp_pkg::OUT_W-1:0]  m_tdata    // channel, value, saturated, zero pad
);

  localparam int IW    = 31 - FRACTION_BITS;
  localparam int FDW   = $clog2(ttp_pkg::pow10(FRACTION_DIGITS));
  localparam int REC_W = ttp_pkg::CHAN_W + 3 + ttp_pkg::FCNT_W + FDW + IW;

  logic             take, emit, push, full, pop, empty;
  logic [REC_W-1:0] rec_in, rec_out;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;
  assign push     = take && emit;

  ttp_front #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .FRACTION_BITS   (FRACTION_BITS),
    .REC_W           (REC_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .byte_in      (s_tdata),
    .buffer_start (s_tuser[0]),
    .emit         (emit),
    .rec          (rec_in)
  );

  ttp_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rec_in),
    .full      (full),
    .pop       (pop),
    .pop_data  (rec_out),
    .empty     (empty)
  );

  ttp_back #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .FRACTION_BITS   (FRACTION_BITS),
    .REC_W           (REC_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .rec      (rec_out),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== dv/tb.sv =====
// Testbench for the tagged telemetry text parser: byte stimulus, predictor and result checks.
`timescale 1ns / 100ps

module tb;

  localparam int FB          = ttp_pkg::FRACTION_BITS_DEF;
  localparam int FD          = ttp_pkg::FRACTION_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4 * (FB + 3);

  // Number parser phases
  typedef enum logic [2:0] {
    PH_LEAD, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_TRAIL
  } phase_t;

  // One tagged reading as packed on m_tdata, lsb first: channel, value, saturated
  typedef struct packed {
    logic        saturated;
    logic [31:0] value;
    logic [3:0]  channel;
  } reading_t;

  // Tracks parser state per accepted byte and holds the readings still owed
  class telemetry_scoreboard;
    logic [23:0] tag_buf;
    logic [2:0]  tag_cnt;
    bit          num_seen;
    bit          is_neg;
    logic [15:0] int_part;
    bit          int_clamped;
    logic [13:0] frac_part;
    logic [2:0]  frac_digits;
    phase_t      phase;
    bit          num_bad;
    reading_t    owed_q[$];
    int          errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      tag_buf     = '0;
      tag_cnt     = '0;
      num_seen    = 0;
      is_neg      = 0;
      int_part    = '0;
      int_clamped = 0;
      frac_part   = '0;
      frac_digits = '0;
      phase       = PH_LEAD;
      num_bad     = 0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == ttp_pkg::CH_SPACE || (c >= ttp_pkg::CH_TAB && c <= ttp_pkg::CH_CR);
    endfunction

    function void int_digit(logic [3:0] d);
      logic [31:0] n;
      if (int_clamped) return;
      n = int_part * 10 + d;
      if (n > (32'd1 << (31 - FB)) - 1) begin
        int_clamped = 1;
        int_part    = 16'((32'd1 << (31 - FB)) - 1);
      end else begin
        int_part = n[15:0];
      end
    endfunction

    function void frac_digit(logic [3:0] d);
      if (frac_digits < FD) begin
        frac_part   = 14'(frac_part * 10 + d);
        frac_digits = frac_digits + 3'd1;
      end
    endfunction

    // Number syntax walk for one non-letter byte
    function void number_char(logic [7:0] c);
      bit         dig;
      logic [3:0] d;
      dig = c >= ttp_pkg::CH_0 && c <= ttp_pkg::CH_9;
      d   = 4'(c - ttp_pkg::CH_0);
      num_seen = 1;
      if (num_bad) return;
      if (phase == PH_LEAD && is_ws(c)) return;
      if (phase == PH_LEAD && (c == ttp_pkg::CH_PLUS || c == ttp_pkg::CH_MINUS)) begin
        is_neg = (c == ttp_pkg::CH_MINUS);
        phase  = PH_SIGN;
        return;
      end
      case (phase)
        PH_LEAD, PH_SIGN: begin
          if (dig) begin int_digit(d); phase = PH_INT; return; end
          if (c == ttp_pkg::CH_DOT) begin phase = PH_DOT; return; end
        end
        PH_INT: begin
          if (dig) begin int_digit(d); return; end
          if (c == ttp_pkg::CH_DOT) begin phase = PH_FRAC; return; end
          if (is_ws(c)) begin phase = PH_TRAIL; return; end
        end
        PH_DOT: begin
          if (dig) begin frac_digit(d); phase = PH_FRAC; return; end
        end
        PH_FRAC: begin
          if (dig) begin frac_digit(d); return; end
          if (is_ws(c)) begin phase = PH_TRAIL; return; end
        end
        PH_TRAIL: begin
          if (is_ws(c)) return;
        end
        default: ;
      endcase
      num_bad = 1;
    endfunction

    // Fixed-point conversion of the pending number
    function reading_t close_number(logic [3:0] ch);
      reading_t    r;
      logic [63:0] scale, frac_q, mag, limit;
      r.channel   = ch;
      r.value     = '0;
      r.saturated = 0;
      if (num_bad || !(phase == PH_INT || phase == PH_FRAC || phase == PH_TRAIL)) return r;
      scale = 1;
      for (int i = 0; i < frac_digits; i++) scale = scale * 10;
      frac_q = ((64'(frac_part) << FB) + scale / 2) / scale;
      mag    = (64'(int_part) << FB) + frac_q;
      limit  = is_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (int_clamped || mag > limit) begin
        mag         = limit;
        r.saturated = 1;
      end
      r.value = is_neg ? 32'h0 - mag[31:0] : mag[31:0];
      return r;
    endfunction

    // Called for every accepted input byte
    function void note_byte(logic [7:0] c, logic start);
      if (start) clear();
      if (c >= ttp_pkg::CH_A && c <= ttp_pkg::CH_Z) begin
        if (num_seen) begin
          for (int k = 0; k < ttp_pkg::NUM_CHANNELS; k++) begin
            if (tag_cnt == ttp_pkg::TAG_LEN[k] && tag_buf == ttp_pkg::TAG_CODE[k]) begin
              owed_q.push_back(close_number(4'(k)));
              break;
            end
          end
          clear();
        end
        if (c != ttp_pkg::CH_D) begin
          tag_buf = {tag_buf[15:0], c};
          if (tag_cnt < 4) tag_cnt = tag_cnt + 3'd1;
        end
      end else begin
        number_char(c);
      end
    endfunction

    // Called for every accepted output reading
    function void check_reading(logic [ttp_pkg::OUT_W-1:0] data);
      reading_t got, want;
      got = data[36:0];
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected reading ch=%0d value=%h sat=%0b",
                   got.channel, got.value, got.saturated);
        return;
      end
      want = owed_q.pop_front();
      if (got.channel !== want.channel || got.value !== want.value ||
          got.saturated !== want.saturated) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: reading exp ch=%0d value=%h sat=%0b got ch=%0d value=%h sat=%0b",
                   want.channel, want.value, want.saturated,
                   got.channel, got.value, got.saturated);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [ttp_pkg::IN_W-1:0]   s_tdata = '0;   // byte_in
  logic [ttp_pkg::USER_W-1:0] s_tuser = '0;   // buffer_start
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [ttp_pkg::OUT_W-1:0]  m_tdata;        // channel, value, saturated, zero pad

  telemetry_scoreboard sb = new();
  int idle_pct = 31;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  tagged_telemetry_text_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Output side: random backpressure, checks at the rising edge
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_reading(m_tdata);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Present one byte, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tuser  = start;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b, start);
    bytes_sent++;
    if (bytes_sent >= 350 && bytes_sent < 500) idle_pct = 0;
    else idle_pct = 31;
    @(negedge clk);
  endtask

  task automatic send_text(input string txt, input logic start);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], start && i == 0);
  endtask

  function automatic logic [7:0] ws_char();
    return ($urandom_range(3) == 0) ? ttp_pkg::CH_SPACE :
           8'($urandom_range(ttp_pkg::CH_TAB, ttp_pkg::CH_CR));
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(ttp_pkg::CH_0 + $urandom_range(9));
  endfunction

  // One tag and number, mostly well formed
  task automatic send_record();
    logic [7:0] rec[$];
    int         ch, n, kind;
    string      big;
    rec = {};
    kind = $urandom_range(99);
    if (kind < 8) begin
      // line noise
      n = $urandom_range(1, 6);
      repeat (n) rec.push_back(8'($urandom_range(255)));
    end else begin
      if (kind < 88) begin
        ch = $urandom_range(ttp_pkg::NUM_CHANNELS - 1);
        for (int i = ttp_pkg::TAG_LEN[ch] - 1; i >= 0; i--) begin
          if ($urandom_range(9) == 0) rec.push_back(ttp_pkg::CH_D);
          rec.push_back(ttp_pkg::TAG_CODE[ch][8*i +: 8]);
        end
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) rec.push_back(8'($urandom_range(ttp_pkg::CH_A, ttp_pkg::CH_Z)));
      end
      repeat ($urandom_range(0, 2) * ($urandom_range(2) == 0)) rec.push_back(ws_char());
      case ($urandom_range(2))
        1: rec.push_back(ttp_pkg::CH_PLUS);
        2: rec.push_back(ttp_pkg::CH_MINUS);
        default: ;
      endcase
      n = $urandom_range(9);
      if (n == 9) begin
        big = ($urandom_range(1) == 0) ? "32767" : "32768";
        for (int i = 0; i < big.len(); i++) rec.push_back(big[i]);
      end else begin
        if (n >= 6) n = n - 2;
        if (n == 7) n = 6;
        repeat (n) rec.push_back(digit_char());
      end
      if ($urandom_range(1) == 0) begin
        rec.push_back(ttp_pkg::CH_DOT);
        repeat ($urandom_range(0, 7)) rec.push_back(digit_char());
      end
      if ($urandom_range(3) == 0) rec.push_back(ws_char());
      // broken syntax now and then
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0:       rec.insert($urandom_range(rec.size()), 8'h45);
          1:       rec.insert($urandom_range(rec.size()), ttp_pkg::CH_DOT);
          default: rec.insert($urandom_range(rec.size()), 8'($urandom_range(255)));
        endcase
      end
    end
    for (int i = 0; i < rec.size(); i++)
      send_byte(rec[i], i == 0 && $urandom_range(19) == 0);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: overflowed negative with extra fraction digits, bare point with sign,
    // exponent form, an unknown tag, skipped d, byte extremes, buffer restart
    send_text("oi-40000.77777", 1'b1);
    send_text("acx+.5E", 1'b0);
    send_text("zz 7", 1'b0);
    send_byte(ttp_pkg::CH_D, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    while (bytes_sent < RANDOM_ITEMS) send_record();
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
